>>> rtl/dobbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dobbq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 256;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int SIZE_W = 24;
	localparam int OUT_CNT_W = 9;

	// register reset values
	localparam logic [SIZE_W-1:0] MAX_PAYLOAD_RST = 24'd1048576;
	localparam logic [SIZE_W-1:0] BYTE_BUDGET_RST = 24'd4194304;

	// register indexes (paddr[2])
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_BYTE_BUDGET = 1'b1;

	// commands
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [SIZE_W-1:0] event_size;
	} req_word_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] dropped_old;
		logic                 accepted;
		logic                 pop_valid;
		logic [SIZE_W-1:0]    pop_size;
		logic [OUT_CNT_W-1:0] occupancy;
		logic [SIZE_W-1:0]    bytes_held;
	} rsp_word_t;

	typedef struct packed {
		logic [SIZE_W-1:0] max_payload_bytes;
		logic [SIZE_W-1:0] byte_budget;
	} cfg_t;

	typedef struct packed {
		logic [SIZE_W-1:0] a;
		logic [SIZE_W-1:0] b;
		logic              sub;
	} alu_req_t;

	// ring pointer advance with wrap
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/drop_oldest_byte_budget_queue.sv
// Sequencing: a word is accepted when start is high and busy low; it is
// registered into the CMD state, and its result is registered onto rsp with
// done high as the sequencer returns to idle. Each dropped old entry adds a pass
// through the DROP state (one read and one subtract) before CMD runs again.
// Busy stays high until a word is done, so a new word waits for the last result.
// Results cannot be stalled. Reset (arst_n low) empties the queue and restores
// the register defaults; the size store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module drop_oldest_byte_budget_queue (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  dobbq_pkg::req_word_t  req,
	output logic                        busy,
	output logic                        done,
	output dobbq_pkg::rsp_word_t        rsp,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [2:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import dobbq_pkg::*;

	cfg_t              cfg_q;
	alu_req_t          alu_op;
	logic [SIZE_W:0]   alu_res;
	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [SIZE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PTR_W-1:0]  ram_raddr;
	logic [SIZE_W-1:0] ram_rdata;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_bytes <= MAX_PAYLOAD_RST;
			cfg_q.byte_budget       <= BYTE_BUDGET_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_MAX_PAYLOAD: cfg_q.max_payload_bytes <= pwdata[SIZE_W-1:0];
				REG_BYTE_BUDGET: cfg_q.byte_budget       <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[2])
			REG_MAX_PAYLOAD: prdata = {(32 - SIZE_W)'(0), cfg_q.max_payload_bytes};
			REG_BYTE_BUDGET: prdata = {(32 - SIZE_W)'(0), cfg_q.byte_budget};
			default:         prdata = '0;
		endcase
	end

	dobbq_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dobbq_alu u_alu (
		.op (alu_op),
		.res(alu_res)
	);

	dobbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cfg      (cfg_q),
		.busy     (busy),
		.done     (done),
		.rsp      (rsp),
		.alu_op   (alu_op),
		.alu_res  (alu_res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

endmodule
`default_nettype wire

>>> rtl/dobbq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dobbq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/dobbq_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module dobbq_alu (
	input  wire  dobbq_pkg::alu_req_t              op,
	output logic [dobbq_pkg::SIZE_W:0]             res
);
	import dobbq_pkg::*;

	logic [SIZE_W:0] sum;

	// one adder: a + b, or a - b via inverted operand and carry in
	always_comb begin
		sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + (SIZE_W + 1)'(op.sub);
		if (op.sub) begin
			// carry out set means a >= b; otherwise clamp to zero
			res = sum[SIZE_W] ? {1'b0, sum[SIZE_W-1:0]} : '0;
		end else begin
			res = sum;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dobbq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dobbq_ctrl (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  dobbq_pkg::req_word_t       req,
	input  wire  dobbq_pkg::cfg_t            cfg,
	output logic                             busy,
	output logic                             done,
	output dobbq_pkg::rsp_word_t             rsp,
	output dobbq_pkg::alu_req_t              alu_op,
	input  wire  [dobbq_pkg::SIZE_W:0]       alu_res,
	output logic                             ram_we,
	output logic [dobbq_pkg::PTR_W-1:0]      ram_waddr,
	output logic [dobbq_pkg::SIZE_W-1:0]     ram_wdata,
	output logic                             ram_re,
	output logic [dobbq_pkg::PTR_W-1:0]      ram_raddr,
	input  wire  [dobbq_pkg::SIZE_W-1:0]     ram_rdata
);
	import dobbq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMD  = 2'd1;
	localparam logic [1:0] S_DROP = 2'd2;

	logic [1:0]        state_q, state_d;
	logic              cmd_q, cmd_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  tail_q, tail_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SIZE_W-1:0] total_q, total_d;
	logic [CNT_W-1:0]  drop_q, drop_d;
	logic              done_q, done_d;
	rsp_word_t         rsp_q, rsp_d;
	logic              over;
	logic              full;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// shared adder: subtract a popped size, else add the new size
	assign alu_op.a   = total_q;
	assign alu_op.sub = (state_q == S_DROP) || (cmd_q == CMD_DEQ);
	assign alu_op.b   = alu_op.sub ? ram_rdata : size_q;

	assign over = (alu_res > {1'b0, cfg.byte_budget});
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));

	// head read: at accept, and after each drop for the next oldest
	assign ram_re    = (start && !busy) || (state_q == S_DROP);
	assign ram_raddr = (state_q == S_DROP) ? ptr_inc(head_q) : head_q;
	assign ram_waddr = tail_q;
	assign ram_wdata = size_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		size_d  = size_q;
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		total_d = total_q;
		drop_d  = drop_q;
		done_d  = 1'b0;
		rsp_d   = rsp_q;
		ram_we  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d   = req.cmd;
					size_d  = req.event_size;
					drop_d  = '0;
					state_d = S_CMD;
				end
			end
			S_CMD: begin
				rsp_d.dropped_old = OUT_CNT_W'(drop_q);
				rsp_d.accepted    = 1'b0;
				rsp_d.pop_valid   = 1'b0;
				rsp_d.pop_size    = '0;
				if (cmd_q == CMD_DEQ) begin
					if (count_q != '0) begin
						head_d          = ptr_inc(head_q);
						count_d         = count_q - CNT_W'(1);
						total_d         = alu_res[SIZE_W-1:0];
						rsp_d.pop_valid = 1'b1;
						rsp_d.pop_size  = ram_rdata;
					end
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else if (size_q == '0 || size_q > cfg.max_payload_bytes) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else if (count_q != '0 && (full || over)) begin
					state_d = S_DROP;
				end else begin
					// empty or room left: store unless the size alone is too big
					if (!over && !full) begin
						ram_we         = 1'b1;
						tail_d         = ptr_inc(tail_q);
						count_d        = count_q + CNT_W'(1);
						total_d        = alu_res[SIZE_W-1:0];
						rsp_d.accepted = 1'b1;
					end
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
				rsp_d.occupancy  = OUT_CNT_W'(count_d);
				rsp_d.bytes_held = total_d;
			end
			S_DROP: begin
				head_d  = ptr_inc(head_q);
				count_d = count_q - CNT_W'(1);
				total_d = alu_res[SIZE_W-1:0];
				drop_d  = drop_q + CNT_W'(1);
				state_d = S_CMD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			total_q <= '0;
			drop_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			total_q <= total_d;
			drop_q  <= drop_d;
			done_q  <= done_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		size_q <= size_d;
		rsp_q  <= rsp_d;
	end

endmodule
`default_nettype wire
